// ----- rtl/rff_pkg.sv -----
// Shared types, opcodes and status codes of the postfix frame filter.
package rff_pkg;

  // default sizes of the program store and the evaluation stack
  localparam int RFF_CODE_DEPTH  = 64;
  localparam int RFF_STACK_DEPTH = 16;

  // depth of the request queue between front and back
  localparam int RFF_QUEUE_DEPTH = 2;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // opcodes (top byte of a program word)
  localparam logic [7:0] OP_END    = 8'h00;
  localparam logic [7:0] OP_LIT    = 8'h01;
  localparam logic [7:0] OP_SRC    = 8'h10;
  localparam logic [7:0] OP_DST    = 8'h11;
  localparam logic [7:0] OP_PROTO  = 8'h12;
  localparam logic [7:0] OP_SIZE   = 8'h13;
  localparam logic [7:0] OP_BYTE0  = 8'h14;
  localparam logic [7:0] OP_BYTE5  = 8'h19;
  localparam logic [7:0] OP_BYTE6  = 8'h20;
  localparam logic [7:0] OP_BYTE7  = 8'h21;
  localparam logic [7:0] OP_EQ     = 8'h80;
  localparam logic [7:0] OP_BAND   = 8'h81;
  localparam logic [7:0] OP_LAND   = 8'h82;
  localparam logic [7:0] OP_BOR    = 8'h83;
  localparam logic [7:0] OP_LOR    = 8'h84;
  localparam logic [7:0] OP_NE     = 8'h85;
  localparam logic [7:0] OP_LNOT   = 8'h86;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BADOP = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_UNDER = 3'd3;
  localparam logic [2:0] ST_DEPTH = 3'd4;
  localparam logic [2:0] ST_NOEND = 3'd5;

  // one classified request as it travels through the queue
  typedef struct packed {
    logic        is_eval;
    logic [5:0]  prog_addr;
    logic [31:0] prog_word;
    logic [9:0]  src_addr;
    logic [9:0]  dst_addr;
    logic [3:0]  proto;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
  } rff_item_t;

endpackage

// ----- rtl/rpn_frame_filter_core.sv -----
// Top level of the postfix frame filter: front end, queue and back end.
//
//  channel | dir | tdata fields (low bit up)                         | tuser   | tlast
//  in_     | in  | prog_addr, prog_word, src_addr, dst_addr, proto,  | command | -
//          |     | frame_len, frame_data, zero fill to 136 bits      |         |
//  out_    | out | matched, status, zero fill to 8 bits              | -       | -
//
// A program write is handled in the back end's idle state. An evaluation runs a
// fetch state (registered program store read) and then an execute state for
// each program word executed. After reset a clearing pass zeroes every program
// store word; in_tready stays low during it. A two-entry queue lets input
// requests be taken while the back end runs; a held result stalls the back end,
// and the input as well once the queue is full.
module rpn_frame_filter_core
  import rff_pkg::*;
#(
  parameter int CODE_DEPTH  = RFF_CODE_DEPTH,
  parameter int STACK_DEPTH = RFF_STACK_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // prog_addr, prog_word, src_addr, dst_addr, proto,
                                  // frame_len, frame_data
  input  logic         in_tuser,  // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata  // matched, status
);

  logic      clearing;
  logic      q_push, q_ready, q_valid, q_pop;
  rff_item_t q_in, q_out;

  rff_front #(
    .CODE_DEPTH (CODE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_item    (q_in)
  );

  rff_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .ready     (q_ready),
    .push_item (q_in),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_item  (q_out)
  );

  rff_back #(
    .CODE_DEPTH  (CODE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_out),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/rff_front.sv -----
// Front end: accepts input requests, classifies them and feeds the queue.
module rff_front
  import rff_pkg::*;
#(
  parameter int CODE_DEPTH = RFF_CODE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         in_tuser,
  input  logic         clearing,
  output logic         q_push,
  input  logic         q_ready,
  output rff_item_t    q_item
);

  logic accept;
  logic addr_ok;

  // stall while the program store is being cleared or the queue is full
  assign in_tready = q_ready && !clearing;
  assign accept    = in_tvalid && in_tready;

  // unpack the request
  always_comb begin
    q_item.is_eval    = (in_tuser == CMD_EVAL);
    q_item.prog_addr  = in_tdata[5:0];
    q_item.prog_word  = in_tdata[37:6];
    q_item.src_addr   = in_tdata[47:38];
    q_item.dst_addr   = in_tdata[57:48];
    q_item.proto      = in_tdata[61:58];
    q_item.frame_len  = in_tdata[65:62];
    q_item.frame_data = in_tdata[129:66];
  end

  // drop writes beyond the program store
  assign addr_ok = 32'(in_tdata[5:0]) < 32'(CODE_DEPTH);
  assign q_push  = accept && (q_item.is_eval || addr_ok);

`ifndef SYNTHESIS
  a_no_push_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_push) else $error("push during clearing pass");
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready) else $error("push into full queue");
  a_drop_only_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !q_push) |-> !q_item.is_eval) else $error("evaluation dropped");
`endif

endmodule

// ----- rtl/rff_queue.sv -----
// Short request queue between front end and back end.
module rff_queue
  import rff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      ready,
  input  rff_item_t push_item,
  output logic      valid,
  input  logic      pop,
  output rff_item_t pop_item
);

  localparam int QW = $clog2(RFF_QUEUE_DEPTH);
  localparam int CW = $clog2(RFF_QUEUE_DEPTH + 1);

  rff_item_t      mem_r [RFF_QUEUE_DEPTH];
  logic [QW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign ready    = (cnt_r != CW'(RFF_QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rp_r];

  // advance pointers and count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QW'(RFF_QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QW'(RFF_QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RFF_QUEUE_DEPTH)) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ready) else $error("push into full queue");
`endif

endmodule

// ----- rtl/rff_back.sv -----
// Back end: program store, evaluation stack and the token sequencer.
module rff_back
  import rff_pkg::*;
#(
  parameter int CODE_DEPTH  = RFF_CODE_DEPTH,
  parameter int STACK_DEPTH = RFF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_pop,
  input  rff_item_t  q_item,
  output logic       clearing,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata
);

  localparam int PW = $clog2(CODE_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [31:0]   prog_mem [CODE_DEPTH];
  logic [31:0]   stk_mem  [STACK_DEPTH];
  logic [31:0]   prog_rd_r;
  logic [31:0]   stk_rd_r;

  logic [2:0]    st_r, st_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [31:0]   tos_r, tos_nxt;
  rff_item_t     frm_r, frm_nxt;
  logic          res_match_r, res_match_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_data_r, out_data_nxt;

  logic          pw_en;
  logic [PW-1:0] pw_addr;
  logic [31:0]   pw_data;
  logic          sw_en;
  logic [SW-1:0] sw_addr;
  logic [SW-1:0] sr_addr;

  logic [7:0]    op;
  logic [2:0]    byte_idx;
  logic          is_push, is_bin;
  logic [31:0]   push_v, bin_r, a_v, b_v;

  assign clearing   = (st_r == S_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};

  // decode the fetched word
  assign op       = prog_rd_r[31:24];
  assign byte_idx = (op == OP_BYTE6) ? 3'd6 :
                    (op == OP_BYTE7) ? 3'd7 : 3'(op - OP_BYTE0);
  assign a_v      = tos_r;
  assign b_v      = stk_rd_r;
  assign sr_addr  = SW'(depth_r - DW'(2));

  always_comb begin
    is_push = 1'b1;
    push_v  = '0;
    priority if (op == OP_LIT) begin
      push_v = {8'h00, prog_rd_r[23:0]};
    end else if (op == OP_SRC) begin
      push_v = 32'(frm_r.src_addr);
    end else if (op == OP_DST) begin
      push_v = 32'(frm_r.dst_addr);
    end else if (op == OP_PROTO) begin
      push_v = 32'(frm_r.proto);
    end else if (op == OP_SIZE) begin
      push_v = 32'(frm_r.frame_len);
    end else if ((op >= OP_BYTE0 && op <= OP_BYTE5) || op == OP_BYTE6 || op == OP_BYTE7) begin
      push_v = 32'(8'(frm_r.frame_data >> {byte_idx, 3'b000}));
    end else begin
      is_push = 1'b0;
    end
  end

  // two-operand result
  always_comb begin
    is_bin = 1'b1;
    bin_r  = '0;
    unique case (op)
      OP_EQ:   bin_r = 32'(a_v == b_v);
      OP_BAND: bin_r = a_v & b_v;
      OP_LAND: bin_r = 32'((a_v != 0) && (b_v != 0));
      OP_BOR:  bin_r = a_v | b_v;
      OP_LOR:  bin_r = 32'((a_v != 0) || (b_v != 0));
      OP_NE:   bin_r = 32'(a_v != b_v);
      default: is_bin = 1'b0;
    endcase
  end

  // sequence requests and tokens
  always_comb begin
    logic       fin;
    logic [2:0] fin_st;
    fin            = 1'b0;
    fin_st         = ST_OK;
    st_nxt         = st_r;
    pc_nxt         = pc_r;
    depth_nxt      = depth_r;
    tos_nxt        = tos_r;
    frm_nxt        = frm_r;
    res_match_nxt  = res_match_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    q_pop          = 1'b0;
    pw_en          = 1'b0;
    pw_addr        = pc_r;
    pw_data        = '0;
    sw_en          = 1'b0;
    sw_addr        = SW'(depth_r - DW'(1));
    unique case (st_r)
      S_CLEAR: begin
        pw_en  = 1'b1;
        pc_nxt = pc_r + 1'b1;
        if (pc_r == PW'(CODE_DEPTH - 1)) begin
          pc_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.is_eval) begin
            frm_nxt   = q_item;
            pc_nxt    = '0;
            depth_nxt = '0;
            st_nxt    = S_FETCH;
          end else begin
            pw_en   = 1'b1;
            pw_addr = PW'(q_item.prog_addr);
            pw_data = q_item.prog_word;
          end
        end
      end
      S_FETCH: begin
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        priority if (op == OP_END) begin
          fin    = 1'b1;
          fin_st = (depth_r == DW'(1)) ? ST_OK : ST_DEPTH;
        end else if (is_push) begin
          if (depth_r == DW'(STACK_DEPTH)) begin
            fin    = 1'b1;
            fin_st = ST_OVER;
          end else begin
            sw_en     = (depth_r != '0);
            tos_nxt   = push_v;
            depth_nxt = depth_r + 1'b1;
          end
        end else if (op == OP_LNOT) begin
          if (depth_r == '0) begin
            fin    = 1'b1;
            fin_st = ST_UNDER;
          end else begin
            tos_nxt = 32'(tos_r == 0);
          end
        end else if (is_bin) begin
          if (depth_r < DW'(2)) begin
            fin    = 1'b1;
            fin_st = ST_UNDER;
          end else begin
            tos_nxt   = bin_r;
            depth_nxt = depth_r - 1'b1;
          end
        end else begin
          fin    = 1'b1;
          fin_st = ST_BADOP;
        end
        if (fin) begin
          res_status_nxt = fin_st;
          res_match_nxt  = (fin_st == ST_OK) && (tos_r != 0);
          st_nxt         = S_DONE;
        end else if (pc_r == PW'(CODE_DEPTH - 1)) begin
          res_status_nxt = ST_NOEND;
          res_match_nxt  = 1'b0;
          st_nxt         = S_DONE;
        end else begin
          pc_nxt = pc_r + 1'b1;
          st_nxt = S_FETCH;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_status_r, res_match_r};
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      pc_r        <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pc_r        <= pc_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    frm_r        <= frm_nxt;
    res_match_r  <= res_match_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // program store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pw_en) begin
      prog_mem[pw_addr] <= pw_data;
    end
    prog_rd_r <= prog_mem[pc_r];
  end

  // stack below the top entry: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (sw_en) begin
      stk_mem[sw_addr] <= tos_r;
    end
    stk_rd_r <= stk_mem[sr_addr];
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH)) else $error("stack depth out of range");
  a_exec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EXEC) |-> ($past(st_r) == S_FETCH)) else $error("exec without fetch");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == S_IDLE)) else $error("queue popped while busy");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && st_nxt == S_IDLE) |=> out_valid_r) else $error("result lost");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the postfix frame filter: program loads and frame evaluations.
module tb_top;
  import rff_pkg::*;

  localparam int CODE_N  = RFF_CODE_DEPTH;
  localparam int STACK_N = RFF_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic       matched;
    logic [2:0] status;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;

  // predictor copy of the program store
  logic [31:0]  prog_mirror [CODE_N];
  verdict_t     verdict_q [$];
  int           err_count = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  rpn_frame_filter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #2 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // evaluate one frame against the mirrored program
  function automatic verdict_t eval_frame(logic [9:0] src, logic [9:0] dst, logic [3:0] pr,
                                          logic [3:0] len, logic [63:0] data);
    logic [31:0] stk [STACK_N];
    logic [31:0] a, b, r, w;
    logic [7:0]  op;
    int          sp;
    int          idx;
    logic        is_push;
    verdict_t    v;
    sp = 0;
    v = '0;
    for (int pc = 0; pc < CODE_N; pc++) begin
      w = prog_mirror[pc];
      op = w[31:24];
      is_push = 1'b1;
      if (op == OP_END) begin
        if (sp != 1) begin
          v.status = ST_DEPTH;
        end else begin
          v.matched = (stk[0] != 0);
          v.status = ST_OK;
        end
        return v;
      end
      if (op == OP_LIT) r = {8'h0, w[23:0]};
      else if (op == OP_SRC) r = {22'h0, src};
      else if (op == OP_DST) r = {22'h0, dst};
      else if (op == OP_PROTO) r = {28'h0, pr};
      else if (op == OP_SIZE) r = {28'h0, len};
      else if ((op >= OP_BYTE0 && op <= OP_BYTE5) || op == OP_BYTE6 || op == OP_BYTE7) begin
        idx = (op >= OP_BYTE6) ? (op - OP_BYTE6 + 6) : (op - OP_BYTE0);
        r = {24'h0, data[8*idx +: 8]};
      end else if (op == OP_LNOT) begin
        if (sp == 0) begin
          v.status = ST_UNDER;
          return v;
        end
        sp--;
        r = (stk[sp] == 0) ? 32'd1 : 32'd0;
      end else if (op >= OP_EQ && op <= OP_NE) begin
        if (sp < 2) begin
          v.status = ST_UNDER;
          return v;
        end
        a = stk[sp-1];
        b = stk[sp-2];
        sp -= 2;
        case (op)
          OP_EQ:   r = 32'(a == b);
          OP_BAND: r = a & b;
          OP_LAND: r = 32'(a != 0 && b != 0);
          OP_BOR:  r = a | b;
          OP_LOR:  r = 32'(a != 0 || b != 0);
          default: r = 32'(a != b);
        endcase
      end else begin
        v.status = ST_BADOP;
        return v;
      end
      if (is_push) begin
        if (sp >= STACK_N) begin
          v.status = ST_OVER;
          return v;
        end
        stk[sp] = r;
        sp++;
      end
    end
    v.status = ST_NOEND;
    return v;
  endfunction

  // send one request, updating the predictor on acceptance
  task automatic send_request(logic cmd, logic [5:0] addr, logic [31:0] word,
                              logic [9:0] src, logic [9:0] dst, logic [3:0] pr,
                              logic [3:0] len, logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {data, len, pr, dst, src, word, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_WRITE) prog_mirror[addr] = word;
    else verdict_q.push_back(eval_frame(src, dst, pr, len, data));
    @(negedge clk);
  endtask

  task automatic load_word(int addr, logic [31:0] word);
    send_request(CMD_WRITE, addr[5:0], word, 10'($urandom), 10'($urandom), 4'($urandom),
                 4'($urandom), {$urandom, $urandom});
  endtask

  task automatic eval_random_frame();
    send_request(CMD_EVAL, 6'($urandom), $urandom, 10'($urandom), 10'($urandom),
                 4'($urandom), 4'($urandom_range(15)), {$urandom, $urandom});
  endtask

  // drop the request line and drain outstanding results before the next phase
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // receiver: random stall and result check
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want.matched || out_tdata[3:1] !== want.status ||
            out_tdata[7:4] !== 4'h0) begin
          $display("%0t: result mismatch expected matched=%0d status=%0d actual %h",
                   $time, want.matched, want.status, out_tdata);
          err_count++;
        end
      end
    end
  end

  // directed: empty program, end word with literal, every operator and every push but bytes 1 to 5
  task automatic test_directed();
    eval_random_frame();                       // end at depth zero
    load_word(0, {OP_END, 24'hffffff});
    eval_random_frame();
    load_word(0, {OP_SRC, 24'h0});
    load_word(1, {OP_DST, 24'h0});
    load_word(2, {OP_NE, 24'h0});
    load_word(3, {OP_END, 24'h123456});
    send_request(CMD_EVAL, '0, '0, 10'h3ff, 10'h3ff, 4'hf, 4'hf, '1);
    send_request(CMD_EVAL, '0, '0, 10'h000, 10'h3ff, 4'h0, 4'h0, '0);
    // walk bytes 0, 7 and 6, size and proto through logical, bitwise and equality operators
    load_word(0, {OP_BYTE0, 24'h0});
    load_word(1, {OP_BYTE7, 24'h0});
    load_word(2, {OP_LAND, 24'h0});
    load_word(3, {OP_BYTE6, 24'h0});
    load_word(4, {OP_LOR, 24'h0});
    load_word(5, {OP_LNOT, 24'h0});
    load_word(6, {OP_SIZE, 24'h0});
    load_word(7, {OP_PROTO, 24'h0});
    load_word(8, {OP_BAND, 24'h0});
    load_word(9, {OP_BOR, 24'h0});
    load_word(10, {OP_LIT, 24'hffffff});
    load_word(11, {OP_EQ, 24'h0});
    load_word(12, {OP_END, 24'h0});
    send_request(CMD_EVAL, '0, '0, '0, '0, 4'h9, 4'h9, 64'h0102030405060708);
    send_request(CMD_EVAL, '0, '0, '0, '0, 4'h0, 4'h8, 64'h0);
    load_word(0, 32'h4200_0000);               // bad opcode
    eval_random_frame();
    load_word(0, {OP_LNOT, 24'h0});            // underrun
    eval_random_frame();
    wait_drained();
  endtask

  // overflow and missing end word
  task automatic test_stack_limits();
    for (int i = 0; i < CODE_N; i++) load_word(i, {OP_LIT, 24'(i)});
    eval_random_frame();
    for (int i = STACK_N - 1; i < CODE_N; i++) load_word(i, {OP_LNOT, 24'h0});
    eval_random_frame();                       // no end word
    wait_drained();
  endtask

  // random well-formed programs with random content, plus noise
  task automatic test_random_programs(int frames);
    logic [7:0] pushes [12] = '{OP_LIT, OP_SRC, OP_DST, OP_PROTO, OP_SIZE, OP_BYTE0,
                                8'h15, 8'h17, OP_BYTE5, OP_BYTE6, OP_BYTE7, OP_LIT};
    int len, pos, depth;
    logic [7:0] op;
    int sent = 0;
    while (sent < frames) begin
      len = $urandom_range(1, 12);
      pos = 0;
      depth = 0;
      for (int k = 0; k < len && pos < CODE_N - 1; k++) begin
        if (depth >= 2 && $urandom_range(1)) op = OP_EQ + 8'($urandom_range(6));
        else if (depth == 1 && $urandom_range(3) == 0) op = OP_LNOT;
        else op = pushes[$urandom_range(11)];
        if ($urandom_range(19) == 0) op = 8'($urandom);
        load_word(pos, {op, 24'($urandom)});
        pos++;
        if (op >= OP_EQ && op <= OP_NE) depth--;
        else if (op != OP_LNOT) depth++;
      end
      while (depth > 1 && pos < CODE_N - 1 && $urandom_range(7) != 0) begin
        load_word(pos, {OP_EQ + 8'($urandom_range(6)), 24'($urandom)});
        pos++;
        depth--;
      end
      load_word(pos, {OP_END, 24'($urandom)});
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(3) == 0) begin
          send_request(CMD_EVAL, '0, '0, 10'($urandom), 10'($urandom), 4'($urandom),
                       4'($urandom), {$urandom, $urandom});
        end else begin
          // keep fields small so equality between them often holds
          send_request(CMD_EVAL, '0, '0, 10'($urandom_range(3)), 10'($urandom_range(3)),
                       4'($urandom_range(3)), 4'($urandom_range(8)),
                       {8{8'($urandom_range(3))}});
        end
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < CODE_N; i++) prog_mirror[i] = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 6;
    recv_idle_pct = 58;
    test_directed();
    test_stack_limits();
    test_random_programs(70);
    send_idle_pct = 58;
    recv_idle_pct = 6;
    test_random_programs(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_programs(70);
    wait_drained();
    repeat (200) @(negedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
